>>> src/ptu_pkg.sv
// ptu_pkg: shared types and constants for the perfect number test unit.
// No dependencies. Used by ptu_ctrl, ptu_dpath and perfect_number_test_unit.
package ptu_pkg;

   localparam int SUM_W = 36;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // Controller to datapath commands
   typedef struct packed {
      logic load_n;    // capture number, clear sum, trial divisor = 2
      logic acc_one;   // start the sum at 1
      logic div_init;  // start a division of n by d
      logic div_step;  // one restoring division step
      logic add_d;     // sum += d
      logic add_q;     // sum += n / d
      logic inc_d;     // next trial divisor
      logic load_out;  // capture result into output registers
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic n_small;   // n < 2
      logic d_gt_q;    // d > n / d, search done
      logic rem_zero;  // d divides n
      logic q_eq_d;    // d is the square root of n
   } stat_type;

endpackage

>>> src/perfect_number_test_unit.sv
// perfect_number_test_unit: proper divisor sum and perfect flag of a number.
// Work: n is divided bit-serially by each trial divisor in turn; the number of
// trial divisors is floor(sqrt(n)), up to 65535 at 32 bits, and none for n < 2.
// One transaction at a time; the restoring divider, run once per trial
// divisor, sets the rate.
// Reset: synchronous, active high; clears controller state and rsp_valid.
module perfect_number_test_unit #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [NUMBER_WIDTH-1:0]   req_number,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_is_perfect,
   output logic [ptu_pkg::SUM_W-1:0] rsp_divisor_sum
);
   import ptu_pkg::*;

   // Control flow per transaction:
   //   accept n -> n < 2 gives sum 0 directly;
   //   otherwise sum = 1, then for d = 2, 3, ...: divide n by d bit-serially,
   //   stop once d > n/d, and on zero remainder add d and (if distinct) n/d
   //   with saturation at SUM_MAX. The result lands in an output register so
   //   the next request is taken while the previous response waits.
   cmd_type  cmd;
   stat_type stat;

   ptu_ctrl #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptu_dpath #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .number      (req_number),
      .cmd         (cmd),
      .stat        (stat),
      .is_perfect  (rsp_is_perfect),
      .divisor_sum (rsp_divisor_sum)
   );

`ifndef ASSERT_OFF
   // one transaction in flight: an accepted request drops ready next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transaction was in flight");

   // a perfect flag always comes with a real divisor sum (smallest is 6)
   a_perfect_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_perfect) |-> (rsp_divisor_sum >= SUM_W'(6)))
      else $error("perfect flag with implausible divisor sum");

   // the datapath never sees two of division step, add, number load and output load together
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.div_step, cmd.add_d, cmd.add_q, cmd.load_out, cmd.load_n}))
      else $error("conflicting datapath commands");
`endif

endmodule

>>> src/ptu_dpath.sv
// ptu_dpath: number, trial divisor, restoring divider, saturating sum and
// output registers. Depends on ptu_pkg.
module ptu_dpath #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                     clock,
   input  logic [NUMBER_WIDTH-1:0]  number,
   input  ptu_pkg::cmd_type         cmd,
   output ptu_pkg::stat_type        stat,
   output logic                     is_perfect,
   output logic [ptu_pkg::SUM_W-1:0] divisor_sum
);
   import ptu_pkg::*;

   localparam int NW = NUMBER_WIDTH;
   localparam int EW = ((NW > SUM_W) ? NW : SUM_W) + 1;

   logic [NW-1:0]    n_ff,   n_in;
   logic [NW-1:0]    d_ff,   d_in;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic             ovf_ff, ovf_in;
   logic             perf_ff, perf_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic [NW:0]   rem_shift;
   logic [NW:0]   rem_diff;
   logic [NW-1:0] term;
   logic [EW-1:0] sum_ext;

   assign rem_shift = {rem_ff, quo_ff[NW-1]};
   assign rem_diff  = rem_shift - {1'b0, d_ff};
   assign term      = cmd.add_q ? quo_ff : d_ff;
   assign sum_ext   = EW'(acc_ff) + EW'(term);

   always_comb begin
      n_in    = n_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      perf_in = perf_ff;
      sum_in  = sum_ff;
      if (cmd.load_n) begin
         n_in   = number;
         d_in   = NW'(2);
         acc_in = '0;
         ovf_in = 1'b0;
      end
      if (cmd.acc_one) begin
         acc_in = SUM_W'(1);
      end
      if (cmd.div_init) begin
         rem_in = '0;
         quo_in = n_ff;
      end
      if (cmd.div_step) begin
         if (!rem_diff[NW]) begin
            rem_in = rem_diff[NW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[NW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
      end
      if ((cmd.add_d || cmd.add_q) && !ovf_ff) begin
         if (sum_ext > EW'(SUM_MAX)) begin
            acc_in = SUM_MAX;
            ovf_in = 1'b1;
         end else begin
            acc_in = sum_ext[SUM_W-1:0];
         end
      end
      if (cmd.inc_d) begin
         d_in = d_ff + NW'(1);
      end
      if (cmd.load_out) begin
         sum_in  = acc_ff;
         perf_in = !stat.n_small && !ovf_ff && (EW'(acc_ff) == EW'(n_ff));
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      acc_ff  <= acc_in;
      ovf_ff  <= ovf_in;
      perf_ff <= perf_in;
      sum_ff  <= sum_in;
   end

   assign stat.n_small  = (n_ff < NW'(2));
   assign stat.d_gt_q   = (d_ff > quo_ff);
   assign stat.rem_zero = (rem_ff == '0);
   assign stat.q_eq_d   = (quo_ff == d_ff);

   assign is_perfect  = perf_ff;
   assign divisor_sum = sum_ff;

endmodule

>>> src/ptu_ctrl.sv
// ptu_ctrl: sequencing state machine and handshakes for the perfect number
// test unit. Depends on ptu_pkg.
module ptu_ctrl #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ptu_pkg::stat_type stat,
   output ptu_pkg::cmd_type  cmd
);
   import ptu_pkg::*;

   localparam int CNT_W = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_ADD_D  = 3'd4;
   localparam logic [2:0] ST_ADD_Q  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_n = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            if (stat.n_small) begin
               state_in = ST_FINISH;
            end else begin
               cmd.acc_one  = 1'b1;
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUMBER_WIDTH - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.d_gt_q) begin
               state_in = ST_FINISH;
            end else if (stat.rem_zero) begin
               state_in = ST_ADD_D;
            end else begin
               cmd.inc_d    = 1'b1;
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end
         end
         ST_ADD_D: begin
            cmd.add_d = 1'b1;
            if (stat.q_eq_d) begin
               cmd.inc_d    = 1'b1;
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_ADD_Q;
            end
         end
         ST_ADD_Q: begin
            cmd.add_q    = 1'b1;
            cmd.inc_d    = 1'b1;
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_FINISH: begin
            // wait until the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> tb/ptu_sum_checker.sv
`timescale 1ns / 1ps
// ptu_sum_checker: scoreboard for perfect_number_test_unit. Predicts the proper divisor
// sum and perfect flag of each accepted number and compares them with the responses.
// Depends on ptu_pkg (SUM_W, SUM_MAX).
module ptu_sum_checker #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [NUMBER_WIDTH-1:0]   req_number,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_is_perfect,
   input  logic [ptu_pkg::SUM_W-1:0] rsp_divisor_sum,
   output int                        mismatches,
   output int                        pending
);
   import ptu_pkg::*;

   typedef struct {
      logic [NUMBER_WIDTH-1:0] number;
      logic                    is_perfect;
      logic [SUM_W-1:0]        divisor_sum;
   } divisor_result_type;

   divisor_result_type expected_sums [$];

   // Trial division up to the square root; a divisor and its cofactor are added
   // together, the root only once. The sum clips at SUM_MAX and a clipped sum
   // never counts as perfect.
   function automatic divisor_result_type predict_divisor_sum(
      input logic [NUMBER_WIDTH-1:0] number);
      logic [63:0]        n;
      logic [63:0]        d;
      logic [63:0]        q;
      logic [63:0]        total;
      logic               clipped;
      divisor_result_type r;
      n = 64'(number);
      total = '0;
      clipped = 1'b0;
      if (n >= 64'd2) begin
         total = 64'd1;
         for (d = 64'd2; d <= n / d; d++) begin
            if (n % d == 64'd0) begin
               q = n / d;
               total += d + ((q != d) ? q : 64'd0);
               if (total > 64'(SUM_MAX)) begin
                  total = 64'(SUM_MAX);
                  clipped = 1'b1;
               end
            end
         end
      end
      r.number = number;
      r.is_perfect = !clipped && (n >= 64'd2) && (total == n);
      r.divisor_sum = total[SUM_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string detail);
      if (mismatches < 10)
         $display("[%0t] mismatch: %s", $time, detail);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      pending = 0;
   end

   // Response is handled before the request of the same edge, so a result can
   // never be matched against the number accepted at that very edge.
   always @(posedge clock) begin
      divisor_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               report_mismatch($sformatf("result with no request: is_perfect %0b sum %0d",
                  rsp_is_perfect, rsp_divisor_sum));
            end else begin
               want = expected_sums.pop_front();
               if (rsp_is_perfect !== want.is_perfect)
                  report_mismatch($sformatf("n=%0d is_perfect: expected %0b, got %0b",
                     want.number, want.is_perfect, rsp_is_perfect));
               if (rsp_divisor_sum !== want.divisor_sum)
                  report_mismatch($sformatf("n=%0d divisor_sum: expected %0d, got %0d",
                     want.number, want.divisor_sum, rsp_divisor_sum));
            end
         end
         if (req_valid && req_ready)
            expected_sums.push_back(predict_divisor_sum(req_number));
      end
      pending <= expected_sums.size();
   end

endmodule

>>> tb/perfect_number_test_unit_tb.sv
`timescale 1ns / 1ps
// perfect_number_test_unit_tb: stimulus and verdict for perfect_number_test_unit.
// Depends on ptu_pkg, the unit itself and ptu_sum_checker (prediction and compare).
module perfect_number_test_unit_tb;
   import ptu_pkg::*;

   localparam int NUMBER_WIDTH = 32;
   localparam int IDLE_PCT     = 37;    // chance per cycle that a side idles
   localparam int RANDOM_COUNT = 100;
   // Quiet cycles after the last result, to catch a stray extra transaction.
   localparam int SETTLE_CYCLES = 200;
   // The limit must cover the slowest correct run, dominated by 0xFFFFFFFF with
   // its 65535 trial divisors.
   localparam longint unsigned RUN_LIMIT_NS = 64'd300_000_000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [NUMBER_WIDTH-1:0] req_number = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_is_perfect;
   logic [SUM_W-1:0]        rsp_divisor_sum;
   logic                    steady = 1'b0;   // while set, neither side idles
   int                      mismatches;
   int                      pending;

   logic [NUMBER_WIDTH-1:0] corner_numbers [$];
   logic [NUMBER_WIDTH-1:0] small_perfects [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   perfect_number_test_unit #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_perfect (rsp_is_perfect),
      .rsp_divisor_sum(rsp_divisor_sum)
   );

   ptu_sum_checker #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_perfect (rsp_is_perfect),
      .rsp_divisor_sum(rsp_divisor_sum),
      .mismatches     (mismatches),
      .pending        (pending)
   );

   // Response side: ready drops about 37% of the time, except in the steady
   // stretch. These stalls land at random points of the block's work,
   // including the cycle the result shows up.
   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

   // One request transaction. Random idle cycles come first (with noise on the
   // number bus); then valid rises and holds until the edge where ready is seen.
   // Valid is left high on return so back-to-back items never lower and raise it
   // in the same step.
   task automatic send_number(input logic [NUMBER_WIDTH-1:0] value);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         req_number <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_number <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off the sender until every outstanding result has been returned.
   // The checker's count is registered, so look only from the next edge on.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned             kind;
      int unsigned             root;
      logic [NUMBER_WIDTH-1:0] value;

      // Directed numbers: zero and one, the smallest prime, squares (root added
      // once), the perfect numbers that fit in 32 bits, an abundant number, a
      // prime, powers of two and the all-ones maximum (sets every bit).
      corner_numbers = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd12,
                         32'd16, 32'd28, 32'd36, 32'd120, 32'd496, 32'd997,
                         32'd8128, 32'd8191, 32'd65536, 32'd1048576,
                         32'd33550336, 32'hFFFF_FFFF, 32'd5};
      small_perfects = '{32'd6, 32'd28, 32'd496, 32'd8128};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_numbers[i])
         send_number(corner_numbers[i]);

      // Sender pause: block must be fully drained before random traffic starts.
      wait_for_results();

      // Random part. Mostly small numbers, since run time grows with sqrt(n);
      // a few up to 2^20, some perfect squares and some known perfect numbers.
      for (int k = 0; k < RANDOM_COUNT; k++) begin
         steady <= (k >= 40) && (k < 65);
         if (k == 75)
            wait_for_results();
         kind = $urandom_range(99);
         if (kind < 55)
            value = $urandom_range(4095);
         else if (kind < 80)
            value = $urandom_range(65535, 4096);
         else if (kind < 90)
            value = $urandom_range(1048575, 65536);
         else if (kind < 95) begin
            root = $urandom_range(1023, 2);
            value = root * root;
         end else
            value = small_perfects[$urandom_range(3)];
         send_number(value);
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
